// ----- design/nqs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqs_pkg
// Shared types and constants of the queen placement search: board limits,
// register indexes, microcode word layout, micro-operations, branch conditions,
// status flags and addresses.
package nqs_pkg;

  // board limits
  localparam int MAX_N       = 8;
  localparam int ROW_W       = 3;
  localparam int CNT_W       = 4;
  localparam int DIAG_W      = 2 * MAX_N - 1;
  localparam int DIAG_OFFSET = MAX_N - 1;
  localparam int COLS_W      = ROW_W * MAX_N;

  // row holds no queen
  localparam logic [CNT_W-1:0] NO_QUEEN = 4'd15;

  // configuration register indexes
  localparam logic REG_BOARD_SIZE  = 1'b0;
  localparam logic REG_QUEEN_COUNT = 1'b1;

  // datapath micro-operations
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_CLEAR,
    OP_ZERO_COL,
    OP_SCAN,
    OP_POP,
    OP_UNPLACE,
    OP_EXHAUST,
    OP_EMIT_DONE,
    OP_EMIT_SOL
  } op_t;

  // branch conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NO_REQ,
    C_FRESH,
    C_EXHAUSTED,
    C_COMPLETE,
    C_ROW_OUT,
    C_TRY_OUT,
    C_SCAN_MORE,
    C_ROW_ZERO,
    C_EMPTY_ROW,
    C_OUT_BUSY
  } cond_t;

  typedef logic [3:0] upc_t;

  // microcode word: operation, branch condition, taken target, fall target
  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  jmp;
    upc_t  nxt;
  } ucode_t;

  // status flags from datapath to sequencer
  typedef struct packed {
    logic req_seen;
    logic fresh;
    logic exhausted;
    logic complete;
    logic row_out;
    logic try_out;
    logic scan_more;
    logic row_zero;
    logic empty_row;
    logic out_busy;
  } flags_t;

  // microprogram addresses
  localparam upc_t UA_WAIT    = 4'd0;
  localparam upc_t UA_DISP    = 4'd1;
  localparam upc_t UA_DISP2   = 4'd2;
  localparam upc_t UA_CLEAR   = 4'd3;
  localparam upc_t UA_ENTER   = 4'd4;
  localparam upc_t UA_ENTER2  = 4'd5;
  localparam upc_t UA_SETUP   = 4'd6;
  localparam upc_t UA_TRY     = 4'd7;
  localparam upc_t UA_SCAN    = 4'd8;
  localparam upc_t UA_BACK    = 4'd9;
  localparam upc_t UA_POP     = 4'd10;
  localparam upc_t UA_CHECK   = 4'd11;
  localparam upc_t UA_UNPLACE = 4'd12;
  localparam upc_t UA_EXHAUST = 4'd13;
  localparam upc_t UA_DONE    = 4'd14;
  localparam upc_t UA_SOL     = 4'd15;

endpackage

// ----- design/nqs_ucode_rom.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqs_ucode_rom
// Read-only microprogram of the backtracking search, one control word per
// step address.
// ----------------------------------------------------------------------------
module nqs_ucode_rom (
  input  nqs_pkg::upc_t   pc,
  output nqs_pkg::ucode_t word
);

  // program table
  always_comb begin
    unique case (pc)
      // wait for a request, latch restart
      nqs_pkg::UA_WAIT:    word = '{nqs_pkg::OP_ACCEPT, nqs_pkg::C_NO_REQ,
                                    nqs_pkg::UA_WAIT, nqs_pkg::UA_DISP};
      // fresh search or resume
      nqs_pkg::UA_DISP:    word = '{nqs_pkg::OP_NOP, nqs_pkg::C_FRESH,
                                    nqs_pkg::UA_CLEAR, nqs_pkg::UA_DISP2};
      nqs_pkg::UA_DISP2:   word = '{nqs_pkg::OP_NOP, nqs_pkg::C_EXHAUSTED,
                                    nqs_pkg::UA_DONE, nqs_pkg::UA_BACK};
      nqs_pkg::UA_CLEAR:   word = '{nqs_pkg::OP_CLEAR, nqs_pkg::C_ALWAYS,
                                    nqs_pkg::UA_ENTER, nqs_pkg::UA_ENTER};
      // enter a row
      nqs_pkg::UA_ENTER:   word = '{nqs_pkg::OP_NOP, nqs_pkg::C_COMPLETE,
                                    nqs_pkg::UA_SOL, nqs_pkg::UA_ENTER2};
      nqs_pkg::UA_ENTER2:  word = '{nqs_pkg::OP_NOP, nqs_pkg::C_ROW_OUT,
                                    nqs_pkg::UA_BACK, nqs_pkg::UA_SETUP};
      nqs_pkg::UA_SETUP:   word = '{nqs_pkg::OP_ZERO_COL, nqs_pkg::C_ALWAYS,
                                    nqs_pkg::UA_TRY, nqs_pkg::UA_TRY};
      // try columns from the current one
      nqs_pkg::UA_TRY:     word = '{nqs_pkg::OP_NOP, nqs_pkg::C_TRY_OUT,
                                    nqs_pkg::UA_BACK, nqs_pkg::UA_SCAN};
      nqs_pkg::UA_SCAN:    word = '{nqs_pkg::OP_SCAN, nqs_pkg::C_SCAN_MORE,
                                    nqs_pkg::UA_SCAN, nqs_pkg::UA_ENTER};
      // backtrack one row
      nqs_pkg::UA_BACK:    word = '{nqs_pkg::OP_NOP, nqs_pkg::C_ROW_ZERO,
                                    nqs_pkg::UA_EXHAUST, nqs_pkg::UA_POP};
      nqs_pkg::UA_POP:     word = '{nqs_pkg::OP_POP, nqs_pkg::C_ALWAYS,
                                    nqs_pkg::UA_CHECK, nqs_pkg::UA_CHECK};
      nqs_pkg::UA_CHECK:   word = '{nqs_pkg::OP_NOP, nqs_pkg::C_EMPTY_ROW,
                                    nqs_pkg::UA_BACK, nqs_pkg::UA_UNPLACE};
      nqs_pkg::UA_UNPLACE: word = '{nqs_pkg::OP_UNPLACE, nqs_pkg::C_ALWAYS,
                                    nqs_pkg::UA_TRY, nqs_pkg::UA_TRY};
      // answers
      nqs_pkg::UA_EXHAUST: word = '{nqs_pkg::OP_EXHAUST, nqs_pkg::C_ALWAYS,
                                    nqs_pkg::UA_DONE, nqs_pkg::UA_DONE};
      nqs_pkg::UA_DONE:    word = '{nqs_pkg::OP_EMIT_DONE, nqs_pkg::C_OUT_BUSY,
                                    nqs_pkg::UA_DONE, nqs_pkg::UA_WAIT};
      nqs_pkg::UA_SOL:     word = '{nqs_pkg::OP_EMIT_SOL, nqs_pkg::C_OUT_BUSY,
                                    nqs_pkg::UA_SOL, nqs_pkg::UA_WAIT};
    endcase
  end

endmodule

// ----- design/nqs_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqs_sequencer
// Step counter over the microprogram with a conditional two-way branch per
// control word.
// ----------------------------------------------------------------------------
module nqs_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  nqs_pkg::flags_t flags,
  output nqs_pkg::ucode_t word
);

  nqs_pkg::upc_t pc;
  nqs_pkg::upc_t pc_next;
  logic          taken;

  nqs_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  // branch condition select
  always_comb begin
    unique case (word.cond)
      nqs_pkg::C_ALWAYS:    taken = 1'b1;
      nqs_pkg::C_NO_REQ:    taken = !flags.req_seen;
      nqs_pkg::C_FRESH:     taken = flags.fresh;
      nqs_pkg::C_EXHAUSTED: taken = flags.exhausted;
      nqs_pkg::C_COMPLETE:  taken = flags.complete;
      nqs_pkg::C_ROW_OUT:   taken = flags.row_out;
      nqs_pkg::C_TRY_OUT:   taken = flags.try_out;
      nqs_pkg::C_SCAN_MORE: taken = flags.scan_more;
      nqs_pkg::C_ROW_ZERO:  taken = flags.row_zero;
      nqs_pkg::C_EMPTY_ROW: taken = flags.empty_row;
      nqs_pkg::C_OUT_BUSY:  taken = flags.out_busy;
      default:              taken = 1'b1;
    endcase
    pc_next = taken ? word.jmp : word.nxt;
  end

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= nqs_pkg::UA_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- design/nqs_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqs_datapath
// Search state (row choices, attack masks, row and queen counters), the
// column under test and the result register, driven by one micro-operation
// per cycle.
// ----------------------------------------------------------------------------
module nqs_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  nqs_pkg::op_t                          op,
  input  logic                                  req_valid,
  input  logic                                  restart,
  input  logic [nqs_pkg::CNT_W-1:0]             board_size,
  input  logic [nqs_pkg::CNT_W-1:0]             queen_count,
  input  logic                                  rsp_ready,
  output nqs_pkg::flags_t                       flags,
  output logic                                  rsp_valid,
  output logic [nqs_pkg::COLS_W-1:0]            row_columns,
  output logic [nqs_pkg::MAX_N-1:0]             row_occupied,
  output logic                                  solution_found,
  output logic                                  search_done
);

  // search state
  logic [nqs_pkg::CNT_W-1:0]  row_choice [nqs_pkg::MAX_N];
  logic [nqs_pkg::CNT_W-1:0]  cur_row;
  logic [nqs_pkg::CNT_W-1:0]  queens_placed;
  logic [nqs_pkg::MAX_N-1:0]  col_mask;
  logic [nqs_pkg::DIAG_W-1:0] fall_mask;
  logic [nqs_pkg::DIAG_W-1:0] rise_mask;
  logic                       exhausted;
  logic                       pending;
  logic                       restart_l;
  logic [nqs_pkg::CNT_W-1:0]  col;

  // combinational helpers
  logic [nqs_pkg::CNT_W-1:0]  n;
  logic [nqs_pkg::ROW_W-1:0]  r;
  logic [nqs_pkg::CNT_W-1:0]  cur_ch;
  logic [nqs_pkg::ROW_W-1:0]  tcol;
  logic [nqs_pkg::CNT_W-1:0]  fall_idx;
  logic [nqs_pkg::CNT_W-1:0]  rise_idx;
  logic [nqs_pkg::MAX_N-1:0]  col_bit;
  logic [nqs_pkg::DIAG_W-1:0] fall_bit;
  logic [nqs_pkg::DIAG_W-1:0] rise_bit;
  logic                       cell_safe;
  logic                       col_in;
  logic                       out_busy;
  logic                       emit;
  logic [nqs_pkg::COLS_W-1:0] sol_cols;
  logic [nqs_pkg::MAX_N-1:0]  sol_occ;

  // effective size, addressed row and toggle position
  always_comb begin
    n = (board_size > nqs_pkg::CNT_W'(nqs_pkg::MAX_N)) ?
        nqs_pkg::CNT_W'(nqs_pkg::MAX_N) : board_size;
    r      = cur_row[nqs_pkg::ROW_W-1:0];
    cur_ch = row_choice[r];
    tcol   = (op == nqs_pkg::OP_UNPLACE) ? cur_ch[nqs_pkg::ROW_W-1:0]
                                         : col[nqs_pkg::ROW_W-1:0];
    fall_idx = {1'b0, r} + nqs_pkg::CNT_W'(nqs_pkg::DIAG_OFFSET) - {1'b0, tcol};
    rise_idx = {1'b0, r} + {1'b0, tcol};
    col_bit  = nqs_pkg::MAX_N'(1) << tcol;
    fall_bit = nqs_pkg::DIAG_W'(1) << fall_idx;
    rise_bit = nqs_pkg::DIAG_W'(1) << rise_idx;
    cell_safe = !col_mask[tcol] && ((fall_mask & fall_bit) == '0) &&
                ((rise_mask & rise_bit) == '0);
    col_in   = col < n;
    out_busy = rsp_valid && !rsp_ready;
    emit     = ((op == nqs_pkg::OP_EMIT_DONE) || (op == nqs_pkg::OP_EMIT_SOL)) &&
               !out_busy;
  end

  // status flags
  always_comb begin
    flags.req_seen  = req_valid;
    flags.fresh     = restart_l || pending;
    flags.exhausted = exhausted;
    flags.complete  = queens_placed == queen_count;
    flags.row_out   = cur_row >= n;
    flags.try_out   = (cur_row >= n) || (col > n);
    flags.scan_more = col_in && !cell_safe;
    flags.row_zero  = cur_row == '0;
    flags.empty_row = cur_ch == nqs_pkg::NO_QUEEN;
    flags.out_busy  = out_busy;
  end

  // placement gather over all rows
  always_comb begin
    sol_cols = '0;
    sol_occ  = '0;
    for (int i = 0; i < nqs_pkg::MAX_N; i++) begin
      if (row_choice[i] != nqs_pkg::NO_QUEEN) begin
        sol_cols[i*nqs_pkg::ROW_W +: nqs_pkg::ROW_W] = row_choice[i][nqs_pkg::ROW_W-1:0];
        sol_occ[i] = 1'b1;
      end
    end
  end

  // board state and result handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < nqs_pkg::MAX_N; i++) begin
        row_choice[i] <= nqs_pkg::NO_QUEEN;
      end
      cur_row       <= '0;
      queens_placed <= '0;
      col_mask      <= '0;
      fall_mask     <= '0;
      rise_mask     <= '0;
      exhausted     <= 1'b0;
      pending       <= 1'b1;
      rsp_valid     <= 1'b0;
    end else begin
      // load a new word or drop the accepted one
      if (emit) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (op)
        nqs_pkg::OP_CLEAR: begin
          for (int i = 0; i < nqs_pkg::MAX_N; i++) begin
            row_choice[i] <= nqs_pkg::NO_QUEEN;
          end
          cur_row       <= '0;
          queens_placed <= '0;
          col_mask      <= '0;
          fall_mask     <= '0;
          rise_mask     <= '0;
          exhausted     <= 1'b0;
          pending       <= 1'b0;
        end
        nqs_pkg::OP_SCAN: begin
          if (!flags.scan_more) begin
            if (col_in) begin
              col_mask      <= col_mask ^ col_bit;
              fall_mask     <= fall_mask ^ fall_bit;
              rise_mask     <= rise_mask ^ rise_bit;
              row_choice[r] <= col;
              queens_placed <= queens_placed + 1'b1;
            end else begin
              row_choice[r] <= nqs_pkg::NO_QUEEN;
            end
            cur_row <= cur_row + 1'b1;
          end
        end
        nqs_pkg::OP_POP: begin
          cur_row <= cur_row - 1'b1;
        end
        nqs_pkg::OP_UNPLACE: begin
          col_mask      <= col_mask ^ col_bit;
          fall_mask     <= fall_mask ^ fall_bit;
          rise_mask     <= rise_mask ^ rise_bit;
          row_choice[r] <= nqs_pkg::NO_QUEEN;
          if (queens_placed != '0) begin
            queens_placed <= queens_placed - 1'b1;
          end
        end
        nqs_pkg::OP_EXHAUST: begin
          exhausted <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // column under test and latched request
  always_ff @(posedge clk) begin
    unique case (op)
      nqs_pkg::OP_ACCEPT: begin
        if (req_valid) begin
          restart_l <= restart;
        end
      end
      nqs_pkg::OP_ZERO_COL: begin
        col <= '0;
      end
      nqs_pkg::OP_SCAN: begin
        if (flags.scan_more) begin
          col <= col + 1'b1;
        end
      end
      nqs_pkg::OP_UNPLACE: begin
        col <= {1'b0, cur_ch[nqs_pkg::ROW_W-1:0]} + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result payload
  always_ff @(posedge clk) begin
    if (!out_busy) begin
      if (op == nqs_pkg::OP_EMIT_DONE) begin
        row_columns    <= '0;
        row_occupied   <= '0;
        solution_found <= 1'b0;
        search_done    <= 1'b1;
      end else if (op == nqs_pkg::OP_EMIT_SOL) begin
        row_columns    <= sol_cols;
        row_occupied   <= sol_occ;
        solution_found <= 1'b1;
        search_done    <= 1'b0;
      end
    end
  end

endmodule

// ----- design/n_queens_solution_enumerator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// n_queens_solution_enumerator_core
// Backtracking queen placement search under microcode control.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_wr_en/cfg_index/cfg_wdata write board_size (index 0) and queen_count
//   (index 1); both reset to 4. Write them only while no request is open.
//   The req channel carries one word, restart. restart=1 (or the first
//   request after reset) clears the board and searches from the start;
//   restart=0 resumes after the last reported placement.
//   The rsp channel returns one word per request: a placement
//   (solution_found=1) or done (search_done=1, all other fields zero).
//   Latency is data dependent: it grows with every row entered, every column
//   tested and every row backed out. One request is in work at a time; the
//   microcode loop runs one step per cycle while the output does not stall.
//   A finished answer sits in the output register while a new request is
//   taken; if the receiver still stalls when the next answer is ready, the
//   sequencer holds on that step until the register frees.
//   Reset (synchronous) empties the board and restores the register values.
// ----------------------------------------------------------------------------
module n_queens_solution_enumerator_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic                           cfg_index,
  input  logic [nqs_pkg::CNT_W-1:0]      cfg_wdata,
  input  logic                           req_valid,
  output logic                           req_ready,
  input  logic                           restart,
  output logic                           rsp_valid,
  input  logic                           rsp_ready,
  output logic [nqs_pkg::COLS_W-1:0]     row_columns,
  output logic [nqs_pkg::MAX_N-1:0]      row_occupied,
  output logic                           solution_found,
  output logic                           search_done
);

  logic [nqs_pkg::CNT_W-1:0] board_size;
  logic [nqs_pkg::CNT_W-1:0] queen_count;
  nqs_pkg::ucode_t           word;
  nqs_pkg::flags_t           flags;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      board_size  <= 4'd4;
      queen_count <= 4'd4;
    end else if (cfg_wr_en) begin
      if (cfg_index == nqs_pkg::REG_BOARD_SIZE) begin
        board_size <= cfg_wdata;
      end else begin
        queen_count <= cfg_wdata;
      end
    end
  end

  // request taken only on the wait step
  assign req_ready = (word.op == nqs_pkg::OP_ACCEPT);

  nqs_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .word  (word)
  );

  nqs_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .op             (word.op),
    .req_valid      (req_valid),
    .restart        (restart),
    .board_size     (board_size),
    .queen_count    (queen_count),
    .rsp_ready      (rsp_ready),
    .flags          (flags),
    .rsp_valid      (rsp_valid),
    .row_columns    (row_columns),
    .row_occupied   (row_occupied),
    .solution_found (solution_found),
    .search_done    (search_done)
  );

endmodule

// ----- design/nqs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nqs_checker
// Port-level checks of the search block, bound to the top level.
// ----------------------------------------------------------------------------
module nqs_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [nqs_pkg::COLS_W-1:0] row_columns,
  input logic [nqs_pkg::MAX_N-1:0]  row_occupied,
  input logic                       solution_found,
  input logic                       search_done
);

  // no answer right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("answer valid after reset");

  // every answer is either a placement or done
  a_kind: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (solution_found != search_done))
    else $error("answer kind not exclusive");

  // done answer carries an empty board
  a_done_empty: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && search_done) |-> (row_columns == '0 && row_occupied == '0))
    else $error("done answer with board contents");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second request taken back to back");

  // stalled answer holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(row_columns) && $stable(row_occupied) &&
       $stable(solution_found) && $stable(search_done)))
    else $error("stalled answer changed");

endmodule

bind n_queens_solution_enumerator_core nqs_checker u_nqs_checker (.*);
